@@ rtl/gmms_pkg.sv @@
// Shared constants, codes and types for the grid minimum-moves search core.
// Used by gmms_cell, gmms_array, gmms_ctrl, the top level and the checker.
package gmms_pkg;

    // Grid geometry
    localparam int GRID_MAX   = 16;
    localparam int NCELL      = GRID_MAX * GRID_MAX;
    localparam int SIDE_W     = $clog2(GRID_MAX + 1);
    localparam int IDX_W      = $clog2(NCELL + 1);
    localparam int AREA_FW    = 2 * SIDE_W;
    localparam int CFG_W      = 5;
    localparam int CMP_W      = (SIDE_W > CFG_W) ? SIDE_W : CFG_W;
    localparam int MOVES_W    = 8;
    localparam int RESET_SIDE = (GRID_MAX < 16) ? GRID_MAX : 16;
    localparam int RESET_AREA = RESET_SIDE * RESET_SIDE;

    // Status reduction: cells are ORed in registered groups
    localparam int GRP_SIZE = 16;
    localparam int NGRP     = (NCELL + GRP_SIZE - 1) / GRP_SIZE;
    localparam int PAD_W    = NGRP * GRP_SIZE;

    // Cell kinds
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_WALL   = 2'd0;
    localparam kind_t KIND_SOURCE = 2'd1;
    localparam kind_t KIND_TARGET = 2'd2;

    // Data that moves down the chain while the grid loads
    typedef struct packed {
        kind_t kind;
        logic  first_col;
        logic  last_col;
        logic  seed;
        logic  valid;
    } cell_link_t;

    // Commands from the sequencer to the cell row
    typedef struct packed {
        logic clear;
        logic shift;
        logic start;
        logic step;
    } arr_ctrl_t;

    // Registered summary of the wavefront
    typedef struct packed {
        logic hit_any;
        logic front_any;
    } arr_stat_t;

endpackage

@@ rtl/gmms_cell.sv @@
// One grid cell of the wavefront row: stores its kind, column flags and
// reached/front bits. Depends on gmms_pkg.
module gmms_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  gmms_pkg::arr_ctrl_t ctl,
    input  gmms_pkg::cell_link_t link_in,
    input  logic                nbr_row,
    input  logic                prev_col,
    input  logic                next_col,
    output gmms_pkg::cell_link_t link_out,
    output logic                front,
    output logic                hit
);

    gmms_pkg::kind_t kind_reg;
    logic            first_reg;
    logic            last_reg;
    logic            seed_reg;
    logic            valid_reg;
    logic            front_reg;
    logic            reached_reg;
    logic            front_next;

    // Mark an open, unreached cell that touches the current front
    assign front_next = valid_reg && (kind_reg != gmms_pkg::KIND_WALL) && !reached_reg
                        && (nbr_row || (prev_col && !first_reg) || (next_col && !last_reg));

    // Hold kind and column flags; advance them on every load shift
    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            kind_reg  <= link_in.kind;
            first_reg <= link_in.first_col;
            last_reg  <= link_in.last_col;
        end
    end

    // Control bits: clear, load, seed, expand
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg    <= 1'b0;
            valid_reg   <= 1'b0;
            front_reg   <= 1'b0;
            reached_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            seed_reg    <= 1'b0;
            valid_reg   <= 1'b0;
            front_reg   <= 1'b0;
            reached_reg <= 1'b0;
        end
        else if (ctl.shift)
        begin
            seed_reg  <= link_in.seed;
            valid_reg <= link_in.valid;
        end
        else if (ctl.start)
        begin
            front_reg   <= seed_reg && valid_reg;
            reached_reg <= seed_reg && valid_reg;
        end
        else if (ctl.step)
        begin
            front_reg   <= front_next;
            reached_reg <= reached_reg || front_next;
        end
    end

    assign link_out = '{kind: kind_reg, first_col: first_reg, last_col: last_reg,
                        seed: seed_reg, valid: valid_reg};
    assign front    = front_reg;
    assign hit      = front_reg && (kind_reg == gmms_pkg::KIND_TARGET);

endmodule

@@ rtl/gmms_array.sv @@
// Row of gmms_cell instances chained in reverse raster order, with the
// neighbor routing for the active side and registered OR groups. Depends on gmms_pkg.
module gmms_array (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gmms_pkg::arr_ctrl_t           ctl,
    input  gmms_pkg::cell_link_t          head,
    input  logic [gmms_pkg::SIDE_W-1:0]   side,
    output gmms_pkg::arr_stat_t           stat
);

    logic [gmms_pkg::NCELL-1:0] front_vec;
    logic [gmms_pkg::NCELL-1:0] hit_vec;
    logic [gmms_pkg::NCELL-1:0] row_prev;
    logic [gmms_pkg::NCELL-1:0] row_next;
    logic [gmms_pkg::PAD_W-1:0] hit_pad;
    logic [gmms_pkg::PAD_W-1:0] front_pad;
    logic [gmms_pkg::NGRP-1:0]  hit_grp_reg;
    logic [gmms_pkg::NGRP-1:0]  front_grp_reg;
    gmms_pkg::cell_link_t       link [gmms_pkg::NCELL];
    logic                       new_src;

    // Chain slot k holds raster index area-1-k: the row above sits side slots up
    assign row_prev = front_vec >> side;
    assign row_next = front_vec << side;
    assign new_src  = ctl.shift && head.seed;

    genvar k;
    generate
        for (k = 0; k < gmms_pkg::NCELL; k++)
        begin : g_cell
            gmms_pkg::cell_link_t lin;
            logic                 pcol;
            logic                 ncol;

            // Feed the chain; drop older seeds when a newer source enters
            if (k == 0)
            begin : g_head
                assign lin = head;
            end
            else
            begin : g_body
                always_comb
                begin
                    lin      = link[k-1];
                    lin.seed = link[k-1].seed && !new_src;
                end
            end

            if (k + 1 < gmms_pkg::NCELL)
            begin : g_pc
                assign pcol = front_vec[k+1];
            end
            else
            begin : g_pc0
                assign pcol = 1'b0;
            end

            if (k > 0)
            begin : g_nc
                assign ncol = front_vec[k-1];
            end
            else
            begin : g_nc0
                assign ncol = 1'b0;
            end

            gmms_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .link_in  (lin),
                .nbr_row  (row_prev[k] || row_next[k]),
                .prev_col (pcol),
                .next_col (ncol),
                .link_out (link[k]),
                .front    (front_vec[k]),
                .hit      (hit_vec[k])
            );
        end
    endgenerate

    // Reduce the front in registered groups
    assign hit_pad   = gmms_pkg::PAD_W'(hit_vec);
    assign front_pad = gmms_pkg::PAD_W'(front_vec);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_grp_reg   <= '0;
            front_grp_reg <= '0;
        end
        else
        begin
            for (int j = 0; j < gmms_pkg::NGRP; j++)
            begin
                hit_grp_reg[j]   <= |hit_pad[j*gmms_pkg::GRP_SIZE +: gmms_pkg::GRP_SIZE];
                front_grp_reg[j] <= |front_pad[j*gmms_pkg::GRP_SIZE +: gmms_pkg::GRP_SIZE];
            end
        end
    end

    assign stat.hit_any   = |hit_grp_reg;
    assign stat.front_any = |front_grp_reg;

endmodule

@@ rtl/gmms_ctrl.sv @@
// Sequencer: load counting, grid size register, wavefront stepping and the
// result register. Depends on gmms_pkg.
module gmms_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  gmms_pkg::kind_t                cell_kind,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           found,
    output logic [gmms_pkg::MOVES_W-1:0]   min_moves,
    input  logic                           cfg_write,
    input  logic [gmms_pkg::CFG_W-1:0]     cfg_data,
    input  gmms_pkg::arr_stat_t            stat,
    output gmms_pkg::arr_ctrl_t            ctl,
    output gmms_pkg::cell_link_t           head,
    output logic [gmms_pkg::SIDE_W-1:0]    side
);

    localparam logic [1:0] ST_LOAD   = 2'd0;
    localparam logic [1:0] ST_SEED   = 2'd1;
    localparam logic [1:0] ST_SEARCH = 2'd2;

    logic [1:0]                    state_reg, state_next;
    logic [gmms_pkg::SIDE_W-1:0]   side_reg, side_next;
    logic [gmms_pkg::IDX_W-1:0]    area_reg, area_next;
    logic [gmms_pkg::IDX_W-1:0]    load_cnt_reg, load_cnt_next;
    logic [gmms_pkg::SIDE_W-1:0]   col_reg, col_next;
    logic                          src_seen_reg, src_seen_next;
    logic                          grp_live_reg, grp_live_next;
    logic [gmms_pkg::MOVES_W-1:0]  step_reg, step_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          found_reg, found_next;
    logic [gmms_pkg::MOVES_W-1:0]  moves_reg, moves_next;

    logic                          last_cell;
    logic                          col_last;
    logic                          is_src;
    logic                          accept;
    logic                          done;
    logic                          res_found;
    logic [gmms_pkg::MOVES_W-1:0]  res_moves;
    logic [gmms_pkg::CMP_W-1:0]    cfg_ext;
    logic [gmms_pkg::SIDE_W-1:0]   side_cfg;
    logic [gmms_pkg::AREA_FW-1:0]  area_full;

    // Clamp the written size to 1..GRID_MAX and derive the area
    always_comb
    begin
        cfg_ext = gmms_pkg::CMP_W'(cfg_data);
        if (cfg_ext == '0)
            side_cfg = gmms_pkg::SIDE_W'(1);
        else if (cfg_ext > gmms_pkg::CMP_W'(gmms_pkg::GRID_MAX))
            side_cfg = gmms_pkg::SIDE_W'(gmms_pkg::GRID_MAX);
        else
            side_cfg = gmms_pkg::SIDE_W'(cfg_ext);
        area_full = gmms_pkg::AREA_FW'(side_cfg) * gmms_pkg::AREA_FW'(side_cfg);
    end

    // Load position and the cell entering the chain
    assign last_cell = (load_cnt_reg == area_reg - gmms_pkg::IDX_W'(1));
    assign col_last  = (col_reg == side_reg - gmms_pkg::SIDE_W'(1));
    assign is_src    = (cell_kind == gmms_pkg::KIND_SOURCE);
    assign in_ready  = (state_reg == ST_LOAD) && !(out_valid_reg && last_cell);
    assign accept    = in_valid && in_ready;
    assign head      = '{kind: cell_kind, first_col: (col_reg == '0), last_col: col_last,
                         seed: is_src, valid: 1'b1};

    // Next-state logic
    always_comb
    begin
        state_next     = state_reg;
        side_next      = side_reg;
        area_next      = area_reg;
        load_cnt_next  = load_cnt_reg;
        col_next       = col_reg;
        src_seen_next  = src_seen_reg;
        grp_live_next  = grp_live_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        moves_next     = moves_reg;
        ctl            = '0;
        done           = 1'b0;
        res_found      = 1'b0;
        res_moves      = '0;

        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    ctl.shift = 1'b1;
                    if (last_cell)
                    begin
                        load_cnt_next = '0;
                        col_next      = '0;
                        src_seen_next = 1'b0;
                        if (src_seen_reg || is_src)
                            state_next = ST_SEED;
                        else
                            done = 1'b1;
                    end
                    else
                    begin
                        load_cnt_next = load_cnt_reg + gmms_pkg::IDX_W'(1);
                        col_next      = col_last ? '0 : col_reg + gmms_pkg::SIDE_W'(1);
                        if (is_src)
                            src_seen_next = 1'b1;
                    end
                end
            end
            ST_SEED:
            begin
                ctl.start     = 1'b1;
                grp_live_next = 1'b0;
                step_next     = '0;
                state_next    = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                ctl.step      = 1'b1;
                grp_live_next = 1'b1;
                if (grp_live_reg)
                begin
                    if (stat.hit_any)
                    begin
                        done       = 1'b1;
                        res_found  = 1'b1;
                        res_moves  = step_reg;
                        state_next = ST_LOAD;
                    end
                    else if (!stat.front_any)
                    begin
                        done       = 1'b1;
                        state_next = ST_LOAD;
                    end
                    else if (step_reg != {gmms_pkg::MOVES_W{1'b1}})
                    begin
                        step_next = step_reg + gmms_pkg::MOVES_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        // Capture the result and drop the grid; release on the output transaction
        if (done)
        begin
            ctl.clear      = 1'b1;
            out_valid_next = 1'b1;
            found_next     = res_found;
            moves_next     = res_moves;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // A size write abandons the grid being loaded
        if (cfg_write)
        begin
            ctl.clear     = 1'b1;
            load_cnt_next = '0;
            col_next      = '0;
            src_seen_next = 1'b0;
            side_next     = side_cfg;
            area_next     = gmms_pkg::IDX_W'(area_full);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            side_reg      <= gmms_pkg::SIDE_W'(gmms_pkg::RESET_SIDE);
            area_reg      <= gmms_pkg::IDX_W'(gmms_pkg::RESET_AREA);
            load_cnt_reg  <= '0;
            col_reg       <= '0;
            src_seen_reg  <= 1'b0;
            grp_live_reg  <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            side_reg      <= side_next;
            area_reg      <= area_next;
            load_cnt_reg  <= load_cnt_next;
            col_reg       <= col_next;
            src_seen_reg  <= src_seen_next;
            grp_live_reg  <= grp_live_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
        moves_reg <= moves_next;
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign min_moves = moves_reg;
    assign side      = side_reg;

endmodule

@@ rtl/grid_min_moves_search_core.sv @@
// Top level of the grid minimum-moves search core (Lee wavefront).
// Depends on gmms_pkg, gmms_ctrl, gmms_array and gmms_cell.
//
// Usage:
//   Input channel (in_valid/in_ready, cell_kind) carries one grid cell per
//   transaction in raster order: 0 wall, 1 source, 2 target, 3 open.
//   cfg_write/cfg_data set the grid side (0 acts as 1, above 16 acts as 16)
//   and abandon any partly loaded grid; write only while the block is idle.
//   Output channel (out_valid/out_ready, found, min_moves) gives one result
//   per grid: the fewest four-neighbor moves from the last source to the
//   nearest target, or found=0 and min_moves=0.
// Timing:
//   Cells load at one per cycle while in_ready is high. After the last cell
//   the input is held off while the wavefront advances one ring per cycle;
//   a result follows the last cell's transaction through the seed state,
//   the registered group reduction and the ring checks up to the target's
//   distance. With no reachable target the search ends once the front dies
//   out. A grid with no source reports on the cycle after its last cell.
// Reset and stall:
//   Reset sets the side to 16 and empties the grid. The next grid loads while
//   a result waits; only its last cell is held off until the result is taken.
module grid_min_moves_search_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     cell_kind,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           found,
    output logic [gmms_pkg::MOVES_W-1:0]   min_moves,
    input  logic                           cfg_write,
    input  logic [gmms_pkg::CFG_W-1:0]     cfg_data
);

    gmms_pkg::arr_ctrl_t          ctl;
    gmms_pkg::arr_stat_t          stat;
    gmms_pkg::cell_link_t         head;
    logic [gmms_pkg::SIDE_W-1:0]  side;

    gmms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cell_kind (gmms_pkg::kind_t'(cell_kind)),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .found     (found),
        .min_moves (min_moves),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .ctl       (ctl),
        .head      (head),
        .side      (side)
    );

    gmms_array u_array (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .head  (head),
        .side  (side),
        .stat  (stat)
    );

endmodule

@@ rtl/gmms_checker.sv @@
// Port-level checker for grid_min_moves_search_core, attached by bind.
// Depends on gmms_pkg and the top level's port names.
module gmms_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic                           found,
    input logic [gmms_pkg::MOVES_W-1:0]   min_moves
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found) && $stable(min_moves))
        else $error("result changed while stalled");

    // A miss reports zero moves
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> min_moves == '0)
        else $error("miss with nonzero moves");

    // A source is never a target, so a hit is at least one move away
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> min_moves != '0)
        else $error("hit with zero moves");

    // A result appears only after a cell transaction or while input is held off
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready) || $past(in_valid && in_ready))
        else $error("result without a finished grid");

endmodule

bind grid_min_moves_search_core gmms_checker u_gmms_checker (.*);
